// ===== design/racd_pkg.sv =====
// Package for the running-average change detector.
// Shared types, register indexes and constants; no dependencies.
package racd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int AVG_W    = 24;
  localparam int OUT_W    = 32;
  localparam int WEIGHT_W = 7;
  localparam int THRESH_W = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IS_PERCENT = 2'd2;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET    = 7'd50;
  localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 24'd10;

  localparam logic [6:0] DIVISOR = 7'd100;
  localparam int         OFFSET  = 10;

  // (x * RECIP25) >> RECIP25_SHIFT == x / 25 for x < 2^30
  localparam int                   RECIP25_W     = 30;
  localparam logic [RECIP25_W-1:0] RECIP25       = 30'd687194768;
  localparam int                   RECIP25_SHIFT = 34;

  // (x * RECIP100) >> RECIP100_SHIFT == x / 100 for x < 43690
  localparam int                    RECIP100_W     = 14;
  localparam logic [RECIP100_W-1:0] RECIP100       = 14'd10486;
  localparam int                    RECIP100_SHIFT = 20;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight_percent;
    logic [THRESH_W-1:0] change_threshold;
    logic                threshold_is_percent;
  } cfg_t;

endpackage

// ===== design/racd_front.sv =====
// Front end: accepts sample transactions and holds them in a two-entry queue.
// Depends on racd_pkg.
module racd_front import racd_pkg::*; #(
  parameter int VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic [VALUE_BITS-1:0] q_sample
);

  logic [VALUE_BITS-1:0] mem [2];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;
  assign q_sample = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= VALUE_BITS'(in_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/racd_back.sv =====
// Back end: running-average update, divide by 100 (reciprocal multiplication),
// change decision and output register. Depends on racd_pkg.
module racd_back import racd_pkg::*; #(
  parameter int VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [VALUE_BITS-1:0] q_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_changed,
  output logic [AVG_W-1:0]      out_average
);

  localparam int SUM_W       = VALUE_BITS + 3;
  localparam int PROD_W      = VALUE_BITS + 1 + THRESH_W;
  localparam int HUND_W      = VALUE_BITS + 7;
  localparam int MQ_PROD_W   = VALUE_BITS + RECIP25_W;
  localparam int FRAC_W      = 2 * WEIGHT_W;
  localparam int FRAC_PROD_W = FRAC_W + RECIP100_W;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RECIP = 4'd1;
  localparam logic [3:0] S_REM   = 4'd2;
  localparam logic [3:0] S_FRAC  = 4'd3;
  localparam logic [3:0] S_QUOT  = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_AXIS  = 4'd6;
  localparam logic [3:0] S_SCALE = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  logic [3:0]            state;
  logic [VALUE_BITS-1:0] avg_reg;
  logic [VALUE_BITS-1:0] smp;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [VALUE_BITS-1:0] mq;
  logic [6:0]            mr;
  logic [VALUE_BITS:0]   wq;
  logic [FRAC_W-1:0]     part;
  logic [VALUE_BITS:0]   quo;
  logic [VALUE_BITS-1:0] nw;
  logic [VALUE_BITS:0]   axis;
  logic [VALUE_BITS-1:0] dlt;
  logic [PROD_W-1:0]     prod;
  logic [HUND_W-1:0]     hund;

  logic [MQ_PROD_W-1:0]   mq_prod;
  logic [FRAC_PROD_W-1:0] frac_prod;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] s_ext;
  logic signed [SUM_W-1:0] q_ext;
  logic [VALUE_BITS-1:0] gap;
  logic [VALUE_BITS-1:0] lo_raw;
  logic                  flag;
  logic                  out_load;

  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // weight * mag / 100 = weight * (mag / 100) + weight * (mag % 100) / 100
  always_comb begin
    mq_prod   = MQ_PROD_W'(mag >> 2) * MQ_PROD_W'(RECIP25);
    frac_prod = FRAC_PROD_W'(part) * FRAC_PROD_W'(RECIP100);
  end

  always_comb begin
    s_ext = signed'(SUM_W'(smp));
    q_ext = signed'(SUM_W'(quo));
    sum   = neg ? (s_ext - q_ext) : (s_ext + q_ext);
  end

  always_comb begin
    if (nw > avg_reg) begin
      gap    = nw - avg_reg;
      lo_raw = avg_reg;
    end else begin
      gap    = avg_reg - nw;
      lo_raw = nw;
    end
  end

  always_comb begin
    if (cfg.threshold_is_percent) begin
      flag = (prod >= PROD_W'(DIVISOR)) && (prod < PROD_W'(hund));
    end else begin
      flag = (cfg.change_threshold != '0) &&
             (PROD_W'(dlt) > PROD_W'(cfg.change_threshold));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      avg_reg   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_RECIP;
          end
        end
        S_RECIP: state <= S_REM;
        S_REM:   state <= S_FRAC;
        S_FRAC:  state <= S_QUOT;
        S_QUOT:  state <= S_ADD;
        S_ADD:   state <= S_AXIS;
        S_AXIS:  state <= S_SCALE;
        S_SCALE: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            avg_reg <= nw;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        smp <= q_sample;
        if (avg_reg >= q_sample) begin
          mag <= avg_reg - q_sample;
          neg <= 1'b0;
        end else begin
          mag <= q_sample - avg_reg;
          neg <= 1'b1;
        end
      end
      S_RECIP: begin
        mq  <= VALUE_BITS'(mq_prod >> RECIP25_SHIFT);
        neg <= neg && (cfg.weight_percent != '0);
      end
      S_REM: begin
        mr <= 7'(mag - ((mq << 6) + (mq << 5) + (mq << 2)));
        wq <= (VALUE_BITS + 1)'(cfg.weight_percent) * (VALUE_BITS + 1)'(mq);
      end
      S_FRAC: begin
        part <= FRAC_W'(cfg.weight_percent) * FRAC_W'(mr);
      end
      S_QUOT: begin
        quo <= wq + (VALUE_BITS + 1)'(frac_prod >> RECIP100_SHIFT);
      end
      S_ADD: begin
        if (sum < 0) begin
          nw <= '0;
        end else if (sum > signed'(SUM_W'(VALUE_MAX))) begin
          nw <= VALUE_MAX;
        end else begin
          nw <= VALUE_BITS'(sum);
        end
      end
      S_AXIS: begin
        axis <= (VALUE_BITS + 1)'(lo_raw) + (VALUE_BITS + 1)'(OFFSET)
              + (VALUE_BITS + 1)'(gap >> 1);
        dlt  <= gap - (gap >> 1);
      end
      S_SCALE: begin
        prod <= cfg.change_threshold * axis;
        hund <= (HUND_W'(dlt) << 6) + (HUND_W'(dlt) << 5) + (HUND_W'(dlt) << 2);
      end
      S_DONE: begin
        if (out_load) begin
          out_changed <= flag;
          out_average <= AVG_W'(nw);
        end
      end
      default: begin
        smp <= smp;
      end
    endcase
  end

endmodule

// ===== design/running_average_change_detector_unit.sv =====
// Running-average change detector. Each sample transaction folds the sample into
// a stored running average, new = sample + trunc(weight * (old - sample) / 100),
// saturated to VALUE_BITS, and returns the new average with a flag that is set
// when the larger of old+10 and new+10 exceeds their midpoint plus the allowed
// deviation (threshold percent of the midpoint if that is at least 1, or the
// absolute threshold if nonzero). Samples are processed one at a time, through
// the back end's step sequence, the same for any VALUE_BITS: the divide by 100
// done by reciprocal multiplication over four steps, then the update, the
// midpoint, the threshold scaling and the output register. A two-entry input
// queue and an output register let both sides stall independently.
// Configuration writes are always ready.
// Depends on racd_pkg, racd_front, racd_back.
module running_average_change_detector_unit import racd_pkg::*; #(
  parameter int VALUE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [23:0] sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // [0] changed, [24:1] average, zero above
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  logic                  q_valid;
  logic                  q_pop;
  logic [VALUE_BITS-1:0] q_sample;
  logic                  changed;
  logic [AVG_W-1:0]      average;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weight_percent       <= WEIGHT_RESET;
      cfg.change_threshold     <= THRESHOLD_RESET;
      cfg.threshold_is_percent <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WEIGHT:     cfg.weight_percent       <= cfg_data[WEIGHT_W-1:0];
        REG_THRESHOLD:  cfg.change_threshold     <= cfg_data[THRESH_W-1:0];
        REG_IS_PERCENT: cfg.threshold_is_percent <= cfg_data[0];
        default: ;
      endcase
    end
  end

  racd_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_sample (s_axis_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_sample  (q_sample)
  );

  racd_back #(.VALUE_BITS(VALUE_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_sample    (q_sample),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_changed (changed),
    .out_average (average)
  );

  assign m_axis_tdata = {(OUT_W - AVG_W - 1)'(0), average, changed};

endmodule
